### sv/accel_step_and_peak_detector_top_defines.svh
// Assertion macros used by the step and peak detector back end (sapd_back).
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef ACCEL_STEP_AND_PEAK_DETECTOR_TOP_DEFINES_SVH
`define ACCEL_STEP_AND_PEAK_DETECTOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SAPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define SAPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/sapd_pkg.sv
// Shared types and constants of the step and peak detector.
// No dependencies.
package sapd_pkg;

    localparam int unsigned AXIS_W  = 16;
    localparam int unsigned THR_W   = 15;
    localparam int unsigned REFR_W  = 4;
    localparam int unsigned STEPS_W = 16;
    localparam int unsigned SQ_W    = 32;
    localparam int unsigned CFG_AW  = 2;

    localparam logic [CFG_AW-1:0] CFG_STEP_THRESHOLD = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_REFRACTORY     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_REST_LEVEL     = 2'd2;

    localparam logic [THR_W-1:0]  RST_STEP_THRESHOLD = 15'd1400;
    localparam logic [REFR_W-1:0] RST_REFRACTORY     = 4'd3;
    localparam logic [THR_W-1:0]  RST_REST_LEVEL     = 15'd1000;

    // word handed from the front to the back
    typedef struct packed {
        logic [STEPS_W-1:0] steps;
        logic [SQ_W-1:0]    max_square;
        logic               had_frame;
        logic               last;
    } t_sapd_entry;

endpackage

### sv/sapd_front.sv
// Front end: accepts words, forms the squared magnitude on a shared multiplier,
// counts steps and tracks the batch maximum. Uses sapd_pkg.
module sapd_front
    import sapd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [AXIS_W-1:0] i_accel_x,
    input  logic signed [AXIS_W-1:0] i_accel_y,
    input  logic signed [AXIS_W-1:0] i_accel_z,
    input  logic                     i_has_frame,
    input  logic                     i_batch_end,
    input  logic [THR_W-1:0]         i_step_threshold_mg,
    input  logic [REFR_W-1:0]        i_refractory_frames,
    output logic                     o_q_push,
    output t_sapd_entry              o_q_data,
    input  logic                     i_q_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_state;

    t_state                   r_state;
    logic [1:0]               r_phase;
    logic signed [AXIS_W-1:0] r_x, r_y, r_z;
    logic                     r_has, r_last;
    logic [SQ_W-1:0]          r_mag, r_thr2;
    logic [REFR_W-1:0]        r_refr_left, n_refr_left;
    logic [STEPS_W-1:0]       r_steps, n_steps;
    logic [SQ_W-1:0]          r_max, n_max;
    logic                     r_had, n_had;

    logic signed [AXIS_W-1:0]   mul_op;
    logic signed [2*AXIS_W-1:0] mul_prod;

    always_comb begin
        case (r_phase)
            2'd0:    mul_op = r_x;
            2'd1:    mul_op = r_y;
            2'd2:    mul_op = r_z;
            default: mul_op = $signed({1'b0, i_step_threshold_mg});
        endcase
        mul_prod = mul_op * mul_op;
    end

    always_comb begin
        n_refr_left = r_refr_left;
        n_steps     = r_steps;
        n_max       = r_max;
        n_had       = r_had;
        if (r_has) begin
            if (r_refr_left != '0) begin
                n_refr_left = r_refr_left - 1'b1;
            end else if (r_mag > r_thr2) begin
                n_steps     = r_steps + 1'b1;
                n_refr_left = i_refractory_frames;
            end
            if (r_mag > r_max) begin
                n_max = r_mag;
            end
            n_had = 1'b1;
        end
    end

    assign o_full   = (r_state != F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data = '{steps: n_steps, max_square: n_max, had_frame: n_had, last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_phase     <= '0;
            r_refr_left <= '0;
            r_steps     <= '0;
            r_max       <= '0;
            r_had       <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_x     <= i_accel_x;
                        r_y     <= i_accel_y;
                        r_z     <= i_accel_z;
                        r_has   <= i_has_frame;
                        r_last  <= i_batch_end;
                        r_mag   <= '0;
                        r_phase <= '0;
                        r_state <= i_has_frame ? F_MUL : F_PUSH;
                    end
                end
                F_MUL: begin
                    // x, y, z squares accumulate; last pass squares the threshold
                    if (r_phase == 2'd3) begin
                        r_thr2  <= SQ_W'(unsigned'(mul_prod));
                        r_state <= F_PUSH;
                    end else begin
                        r_mag <= r_mag + SQ_W'(unsigned'(mul_prod));
                    end
                    r_phase <= r_phase + 1'b1;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_refr_left <= n_refr_left;
                        r_steps     <= n_steps;
                        r_max       <= r_last ? '0 : n_max;
                        r_had       <= r_last ? 1'b0 : n_had;
                        r_state     <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

### sv/sapd_queue.sv
// Short queue of words between the front and the back.
// Uses sapd_pkg for the word type.
module sapd_queue
    import sapd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_sapd_entry i_data,
    output logic        o_full,
    input  logic        i_pop,
    output t_sapd_entry o_data,
    output logic        o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_sapd_entry      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/sapd_back.sv
// Back end: takes words from the queue, runs the 16-step square root at batch
// end, forms the peak deviation and holds the output register. Uses sapd_pkg.
module sapd_back
    import sapd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_sapd_entry        i_q_data,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [THR_W-1:0]   i_rest_level_mg,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [STEPS_W-1:0] o_step_count,
    output logic [15:0]        o_peak_deviation_mg,
    output logic               o_peak_valid
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQRT,
        B_FIX,
        B_OUT
    } t_state;

    t_state             r_state;
    logic [STEPS_W-1:0] r_steps;
    logic               r_last;
    logic [15:0]        r_peak;
    logic [SQ_W-1:0]    r_rem, r_res, r_bit;
    logic [3:0]         r_cnt;
    logic               r_out_valid;

    logic [SQ_W:0]   trial;
    logic            take;
    logic [15:0]     root, rest16, ceil_root, fix_peak;
    logic            out_free;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign take  = ({1'b0, r_rem} >= trial);

    // below the rest level the root is rounded up unless it is exact
    assign root      = r_res[15:0];
    assign rest16    = {1'b0, i_rest_level_mg};
    assign ceil_root = (r_rem == '0) ? root : root + 1'b1;
    assign fix_peak  = (root >= rest16) ? root - rest16 : rest16 - ceil_root;

    assign out_free = !r_out_valid || i_pop;
    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty  = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a pop in B_OUT is followed by a reload below
            if (i_pop && r_out_valid && (r_state != B_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_steps <= i_q_data.steps;
                        r_last  <= i_q_data.last;
                        r_peak  <= '0;
                        r_rem   <= i_q_data.max_square;
                        r_res   <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 2);
                        r_cnt   <= '0;
                        r_state <= (i_q_data.last && i_q_data.had_frame) ? B_SQRT : B_OUT;
                    end
                end
                B_SQRT: begin
                    if (take) begin
                        r_rem <= r_rem - trial[SQ_W-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_state <= B_FIX;
                    end
                end
                B_FIX: begin
                    r_peak  <= fix_peak;
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        o_step_count        <= r_steps;
                        o_peak_deviation_mg <= r_peak;
                        o_peak_valid        <= r_last;
                        r_out_valid         <= 1'b1;
                        r_state             <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

`include "accel_step_and_peak_detector_top_defines.svh"

`SAPD_ASSERT_NEXT(a_sqrt_bit_drained, (r_state == B_SQRT) && (r_cnt == 4'd15), r_bit == '0, "root bit not drained after last step")
`SAPD_ASSERT_IMP(a_root_fits, r_state == B_FIX, r_res[SQ_W-1:16] == '0, "root wider than 16 bits")
`SAPD_ASSERT_IMP(a_rem_bound, r_state == B_FIX, {1'b0, r_rem} <= ({1'b0, r_res} << 1), "remainder exceeds twice the root")
`SAPD_ASSERT_IMP(a_pop_only_idle, o_q_pop, r_state == B_IDLE, "queue popped while busy")

endmodule

### sv/accel_step_and_peak_detector_top.sv
// Accelerometer step counter and batch peak detector. A frame word makes four
// passes through one shared 16x16 multiplier in the front (x, y, z, threshold);
// a word without a frame goes straight to push. A batch-end word with frames runs
// the 16-step integer square root in the back, then the fix state; other words go
// straight to output. Front and back overlap through a short queue; a result may
// wait in the output register while the next word is taken.
// Depends on sapd_pkg, sapd_front, sapd_queue and sapd_back.
module accel_step_and_peak_detector_top
    import sapd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [AXIS_W-1:0]  i_accel_x,
    input  logic signed [AXIS_W-1:0]  i_accel_y,
    input  logic signed [AXIS_W-1:0]  i_accel_z,
    input  logic                      i_has_frame,
    input  logic                      i_batch_end,
    output logic                      empty,
    input  logic                      pop,
    output logic [STEPS_W-1:0]        o_step_count,
    output logic [15:0]               o_peak_deviation_mg,
    output logic                      o_peak_valid,
    input  logic                      i_cfg_we,
    input  logic [CFG_AW-1:0]         i_cfg_addr,
    input  logic [THR_W-1:0]          i_cfg_wdata
);

    logic [THR_W-1:0]  r_step_threshold_mg;
    logic [REFR_W-1:0] r_refractory_frames;
    logic [THR_W-1:0]  r_rest_level_mg;

    logic        q_push, q_full, q_pop, q_empty;
    t_sapd_entry q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_threshold_mg <= RST_STEP_THRESHOLD;
            r_refractory_frames <= RST_REFRACTORY;
            r_rest_level_mg     <= RST_REST_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP_THRESHOLD: r_step_threshold_mg <= i_cfg_wdata;
                CFG_REFRACTORY:     r_refractory_frames <= i_cfg_wdata[REFR_W-1:0];
                CFG_REST_LEVEL:     r_rest_level_mg     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    sapd_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_accel_x           (i_accel_x),
        .i_accel_y           (i_accel_y),
        .i_accel_z           (i_accel_z),
        .i_has_frame         (i_has_frame),
        .i_batch_end         (i_batch_end),
        .i_step_threshold_mg (r_step_threshold_mg),
        .i_refractory_frames (r_refractory_frames),
        .o_q_push            (q_push),
        .o_q_data            (q_wdata),
        .i_q_full            (q_full)
    );

    sapd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    sapd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_data            (q_rdata),
        .i_q_empty           (q_empty),
        .o_q_pop             (q_pop),
        .i_rest_level_mg     (r_rest_level_mg),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_step_count        (o_step_count),
        .o_peak_deviation_mg (o_peak_deviation_mg),
        .o_peak_valid        (o_peak_valid)
    );

endmodule
